// File: design/grc_pkg.sv
// shared constants, types and the rotation angle table of the grid ray wall caster
package grc_pkg;

  // map size defaults
  localparam int MAP_COLS_DEF = 64;
  localparam int MAP_ROWS_DEF = 64;

  // field and datapath widths
  localparam int FRAC_W    = 8;
  localparam int ANGLE_W   = 16;
  localparam int POS_W     = 20;
  localparam int INT_W     = POS_W - FRAC_W;
  localparam int DIST_W    = 21;
  localparam int TILE_W    = 8;
  localparam int VIEW_W    = 12;
  localparam int TPIX_W    = TILE_W + FRAC_W;
  localparam int NUM_W     = 47;
  localparam int DEN_W     = 31;
  localparam int CNT_W     = 6;
  localparam int COORD_W   = 44;
  localparam int SQ_W      = 42;
  localparam int OFF_W     = 41;
  localparam int ROT_W     = 34;
  localparam int ROT_STEPS = 24;
  localparam int MUL_A_W   = 20;
  localparam int MUL_B_W   = 31;
  localparam int MUL_W     = MUL_A_W + MUL_B_W;

  // saturation value of a walk offset or step
  localparam logic [OFF_W-1:0] OFF_CAP = {1'b1, {(OFF_W-1){1'b0}}};

  // special angles
  localparam logic [ANGLE_W-1:0] A_QUARTER = {2'b01, {(ANGLE_W-2){1'b0}}};
  localparam logic [ANGLE_W-1:0] A_HALF    = {2'b10, {(ANGLE_W-2){1'b0}}};
  localparam logic [ANGLE_W-1:0] A_3Q      = {2'b11, {(ANGLE_W-2){1'b0}}};

  // register indexes on the config port
  typedef enum logic [1:0] {
    REG_TILE   = 2'd0,
    REG_VIEW_W = 2'd1,
    REG_VIEW_H = 2'd2
  } reg_idx_e;

  typedef logic signed [COORD_W-1:0] coord_t;

  // request to the shared divider
  typedef struct packed {
    logic              start;
    logic [CNT_W-1:0]  nbits;
    logic [NUM_W-1:0]  num;
    logic [DEN_W-1:0]  den;
  } div_req_t;

  // outcome of one walk
  typedef struct packed {
    logic              hit;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [DIST_W-1:0] dist_val;
  } walk_res_t;

  // rotation angles, 2^32 per turn
  function automatic logic [31:0] rot_angle(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

// File: design/grc_div.sv
// shared restoring divider, one quotient bit per cycle
module grc_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  grc_pkg::div_req_t         req_i,
  output logic                      busy_o,
  output logic [grc_pkg::NUM_W-1:0] quo_o
);

  logic [grc_pkg::CNT_W-1:0] cnt_q;
  logic [grc_pkg::NUM_W-1:0] num_q;
  logic [grc_pkg::NUM_W-1:0] quo_q;
  logic [grc_pkg::DEN_W-1:0] den_q;
  logic [grc_pkg::DEN_W-1:0] rem_q;
  logic [grc_pkg::DEN_W:0]   rem_sh;
  logic                      ge;

  // trial subtract
  assign rem_sh = {rem_q, num_q[grc_pkg::NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  // iteration count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (req_i.start) begin
      cnt_q <= req_i.nbits;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
      quo_q <= '0;
    end else if (cnt_q != '0) begin
      num_q <= {num_q[grc_pkg::NUM_W-2:0], 1'b0};
      rem_q <= ge ? grc_pkg::DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[grc_pkg::DEN_W-1:0];
      quo_q <= {quo_q[grc_pkg::NUM_W-2:0], ge};
    end
  end

  assign busy_o = cnt_q != '0;
  assign quo_o  = quo_q;

endmodule

// File: design/grc_sqrt.sv
// iterative integer square root, one result bit per cycle
module grc_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [grc_pkg::SQ_W-1:0]   val_i,
  output logic                       busy_o,
  output logic [grc_pkg::DIST_W-1:0] root_o
);

  logic [grc_pkg::SQ_W-1:0] bit_q;
  logic [grc_pkg::SQ_W-1:0] v_q;
  logic [grc_pkg::SQ_W-1:0] r_q;
  logic [grc_pkg::SQ_W-1:0] trial;

  assign trial = r_q + bit_q;

  // bit position walks down two places a step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= '0;
    end else if (start_i) begin
      bit_q <= grc_pkg::SQ_W'(1) << (grc_pkg::SQ_W - 2);
    end else begin
      bit_q <= bit_q >> 2;
    end
  end

  // remainder and partial root
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q <= val_i;
      r_q <= '0;
    end else if (bit_q != '0) begin
      if (v_q >= trial) begin
        v_q <= v_q - trial;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
    end
  end

  assign busy_o = bit_q != '0;
  assign root_o = r_q[grc_pkg::DIST_W-1:0];

endmodule

// File: design/grc_map.sv
// one-bit wall map memory with a clearing pass after reset
module grc_map #(
  parameter int MAP_COLS = grc_pkg::MAP_COLS_DEF,
  parameter int MAP_ROWS = grc_pkg::MAP_ROWS_DEF,
  localparam int DEPTH = MAP_COLS * MAP_ROWS,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  output logic          busy_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic          wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic          rd_data_o
);

  logic          mem [DEPTH];
  logic          clr_q;
  logic [AW-1:0] clr_addr_q;
  logic          rd_data_q;

  // clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == AW'(DEPTH - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  // storage, registered read
  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem[clr_addr_q] <= 1'b0;
    end else if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign busy_o    = clr_q;
  assign rd_data_o = rd_data_q;

endmodule

// File: design/grc_core.sv
// cast sequencer: rotation, offsets, both grid walks and distances
module grc_core #(
  parameter int MAP_COLS = grc_pkg::MAP_COLS_DEF,
  parameter int MAP_ROWS = grc_pkg::MAP_ROWS_DEF,
  localparam int AW = $clog2(MAP_COLS * MAP_ROWS)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [grc_pkg::POS_W-1:0]   pos_x_i,
  input  logic [grc_pkg::POS_W-1:0]   pos_y_i,
  input  logic [grc_pkg::ANGLE_W-1:0] angle_i,
  input  logic [grc_pkg::TILE_W-1:0]  tile_i,
  input  logic [grc_pkg::VIEW_W-1:0]  view_w_i,
  input  logic [grc_pkg::VIEW_W-1:0]  view_h_i,
  output logic                        idle_o,
  input  logic                        res_ready_i,
  output logic                        res_valid_o,
  output grc_pkg::walk_res_t          horiz_o,
  output grc_pkg::walk_res_t          vert_o,
  output logic                        rd_en_o,
  output logic [AW-1:0]               rd_addr_o,
  input  logic                        rd_data_i
);

  typedef enum logic [22:0] {
    ST_IDLE = 23'h000001,
    ST_ROT  = 23'h000002,
    ST_ABS  = 23'h000004,
    ST_PS   = 23'h000008,
    ST_BW   = 23'h000010,
    ST_BM   = 23'h000020,
    ST_OM   = 23'h000040,
    ST_OD   = 23'h000080,
    ST_OW   = 23'h000100,
    ST_SM   = 23'h000200,
    ST_SD   = 23'h000400,
    ST_SW   = 23'h000800,
    ST_WS   = 23'h001000,
    ST_WC   = 23'h002000,
    ST_WCW  = 23'h004000,
    ST_WRW  = 23'h008000,
    ST_WM   = 23'h010000,
    ST_DX   = 23'h020000,
    ST_DY   = 23'h040000,
    ST_DS   = 23'h080000,
    ST_DW   = 23'h100000,
    ST_PE   = 23'h200000,
    ST_DONE = 23'h400000
  } state_e;

  localparam int PW  = grc_pkg::POS_W;
  localparam int FW  = grc_pkg::FRAC_W;
  localparam int IW  = grc_pkg::INT_W;
  localparam int NW  = grc_pkg::NUM_W;
  localparam int DW  = grc_pkg::DEN_W;
  localparam int CW  = grc_pkg::COORD_W;
  localparam int RW  = grc_pkg::ROT_W;
  localparam int OW  = grc_pkg::OFF_W;
  localparam int TW  = grc_pkg::TPIX_W;
  localparam int SQW = grc_pkg::SQ_W;

  state_e state_q, state_d;

  logic                        p_q;
  logic                        right_q, down_q;
  logic [grc_pkg::ANGLE_W-1:0] a_q;
  logic [PW-1:0]               px_q, py_q;
  logic signed [RW-1:0]        z_q, cx_q, cy_q;
  logic [4:0]                  i_q;
  logic [DW-1:0]               ac_q, as_q;
  logic [PW:0]                 base_q;
  logic [TW:0]                 d0_q;
  logic [OW-1:0]               off_q, step_q;
  grc_pkg::coord_t             x_q, y_q, sx_q, sy_q;
  logic [IW-1:0]               col_q;
  logic [SQW-2:0]              sq_q;
  logic [grc_pkg::MUL_W-1:0]   mul_q;
  grc_pkg::walk_res_t          horiz_q, vert_q;

  logic [grc_pkg::MUL_A_W-1:0] mul_a;
  logic [grc_pkg::MUL_B_W-1:0] mul_b;
  grc_pkg::div_req_t           div_req;
  logic                        div_busy;
  logic [NW-1:0]               quo;
  logic                        sq_start;
  logic                        sq_busy;
  logic [grc_pkg::DIST_W-1:0]  root;

  logic [grc_pkg::TILE_W-1:0]  tile_eff;
  logic [TW-1:0]               t_val;
  grc_pkg::coord_t             t_c, wmax_c, hmax_c, px_c, py_c, off_c, step_c, base_c;
  logic                        right_n, down_n;
  logic [31:0]                 u;
  logic signed [RW-1:0]        z0, z_fold, sh_x, sh_y, rot_c;
  logic [DW-1:0]               mulnum, divden;
  logic                        walk_ok, inc;
  logic [PW-1:0]               pb;
  logic [PW:0]                 base_n;
  logic [PW:0]                 d0_n;
  logic                        in_view;
  logic                        col_lower, row_lower;
  logic [IW-1:0]               row_raw, col_l, row_l;
  logic                        cell_fail;
  logic [PW-1:0]               dx, dy;

  // offset saturation
  function automatic logic [OW-1:0] sat_off(input logic [NW-1:0] q);
    if (q > NW'(grc_pkg::OFF_CAP)) begin
      return grc_pkg::OFF_CAP;
    end
    return q[OW-1:0];
  endfunction

  grc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .busy_o (div_busy),
    .quo_o  (quo)
  );

  grc_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .val_i   ({1'b0, sq_q + mul_q[SQW-2:0]}),
    .busy_o  (sq_busy),
    .root_o  (root)
  );

  // tile and view in position units
  assign tile_eff = (tile_i == '0) ? grc_pkg::TILE_W'(1) : tile_i;
  assign t_val    = {tile_eff, {FW{1'b0}}};
  assign t_c      = $signed({{(CW-TW){1'b0}}, t_val});
  assign wmax_c   = $signed({{(CW-PW){1'b0}}, view_w_i, {FW{1'b0}}});
  assign hmax_c   = $signed({{(CW-PW){1'b0}}, view_h_i, {FW{1'b0}}});
  assign px_c     = $signed({{(CW-PW){1'b0}}, px_q});
  assign py_c     = $signed({{(CW-PW){1'b0}}, py_q});
  assign off_c    = $signed({{(CW-OW){1'b0}}, off_q});
  assign step_c   = $signed({{(CW-OW){1'b0}}, step_q});
  assign base_c   = $signed({{(CW-PW-1){1'b0}}, base_q});

  // facing of a new ray and folded start angle
  assign right_n = (angle_i > grc_pkg::A_3Q) ||
                   ((angle_i != '0) && (angle_i < grc_pkg::A_QUARTER));
  assign down_n  = (angle_i != '0) && (angle_i < grc_pkg::A_HALF);
  assign u       = {angle_i, {(32-grc_pkg::ANGLE_W){1'b0}}};
  assign z0      = $signed({{(RW-32){u[31]}}, u});
  always_comb begin
    z_fold = z0;
    if (z0 > 34'sd1073741824) begin
      z_fold = z0 - 34'sd2147483648;
    end else if (z0 < -34'sd1073741824) begin
      z_fold = z0 + 34'sd2147483648;
    end
  end

  // rotation step terms
  assign sh_x  = cx_q >>> i_q;
  assign sh_y  = cy_q >>> i_q;
  assign rot_c = $signed({{(RW-32){1'b0}}, grc_pkg::rot_angle(i_q)});

  // per-walk selection
  assign mulnum  = p_q ? as_q : ac_q;
  assign divden  = p_q ? ac_q : as_q;
  assign walk_ok = p_q ?
      ((a_q != grc_pkg::A_QUARTER) && (a_q != grc_pkg::A_3Q) && (ac_q != '0)) :
      ((a_q != '0) && (a_q != grc_pkg::A_HALF) && (as_q != '0));
  assign pb      = p_q ? px_q : py_q;
  assign inc     = p_q ? right_q : down_q;

  // first grid line and distance to it
  assign base_n = {1'b0, mul_q[PW-1:0]} + (inc ? {{(PW+1-TW){1'b0}}, t_val} : '0);
  assign d0_n   = inc ? base_n - {1'b0, pb} : {1'b0, pb} - base_n;

  // walk cell lookup
  assign in_view   = !x_q[CW-1] && !y_q[CW-1] && (x_q <= wmax_c) && (y_q <= hmax_c);
  assign col_lower = p_q && !right_q;
  assign row_lower = !p_q && !down_q;
  assign row_raw   = quo[IW-1:0];
  assign col_l     = col_q - {{(IW-1){1'b0}}, col_lower};
  assign row_l     = row_raw - {{(IW-1){1'b0}}, row_lower};
  assign cell_fail = (col_lower && (col_q == '0)) || (row_lower && (row_raw == '0)) ||
                     (col_l >= IW'(MAP_COLS)) || (row_l >= IW'(MAP_ROWS));
  assign rd_addr_o = AW'(row_l) * AW'(MAP_COLS) + AW'(col_l);

  // distance legs
  assign dx = (x_q[PW-1:0] >= px_q) ? x_q[PW-1:0] - px_q : px_q - x_q[PW-1:0];
  assign dy = (y_q[PW-1:0] >= py_q) ? y_q[PW-1:0] - py_q : py_q - y_q[PW-1:0];

  // sequencer
  always_comb begin
    state_d     = state_q;
    mul_a       = '0;
    mul_b       = '0;
    div_req     = '0;
    sq_start    = 1'b0;
    rd_en_o     = 1'b0;
    res_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_ROT;
        end
      end
      ST_ROT: begin
        if (i_q == 5'(grc_pkg::ROT_STEPS - 1)) begin
          state_d = ST_ABS;
        end
      end
      ST_ABS: state_d = ST_PS;
      ST_PS: begin
        if (walk_ok) begin
          div_req.start = 1'b1;
          div_req.nbits = grc_pkg::CNT_W'(IW);
          div_req.num   = {pb[PW-1:FW], {(NW-IW){1'b0}}};
          div_req.den   = DW'(tile_eff);
          state_d       = ST_BW;
        end else begin
          state_d = ST_PE;
        end
      end
      ST_BW: begin
        if (!div_busy) begin
          mul_a   = grc_pkg::MUL_A_W'(quo[IW-1:0]);
          mul_b   = grc_pkg::MUL_B_W'(t_val);
          state_d = ST_BM;
        end
      end
      ST_BM: state_d = ST_OM;
      ST_OM: begin
        mul_a   = grc_pkg::MUL_A_W'(d0_q);
        mul_b   = mulnum;
        state_d = ST_OD;
      end
      ST_OD: begin
        div_req.start = 1'b1;
        div_req.nbits = grc_pkg::CNT_W'(NW);
        div_req.num   = mul_q[NW-1:0];
        div_req.den   = divden;
        state_d       = ST_OW;
      end
      ST_OW: begin
        if (!div_busy) begin
          state_d = ST_SM;
        end
      end
      ST_SM: begin
        mul_a   = grc_pkg::MUL_A_W'(t_val);
        mul_b   = mulnum;
        state_d = ST_SD;
      end
      ST_SD: begin
        div_req.start = 1'b1;
        div_req.nbits = grc_pkg::CNT_W'(NW);
        div_req.num   = mul_q[NW-1:0];
        div_req.den   = divden;
        state_d       = ST_SW;
      end
      ST_SW: begin
        if (!div_busy) begin
          state_d = ST_WS;
        end
      end
      ST_WS: state_d = ST_WC;
      ST_WC: begin
        if (in_view) begin
          div_req.start = 1'b1;
          div_req.nbits = grc_pkg::CNT_W'(IW);
          div_req.num   = {x_q[PW-1:FW], {(NW-IW){1'b0}}};
          div_req.den   = DW'(tile_eff);
          state_d       = ST_WCW;
        end else begin
          state_d = ST_PE;
        end
      end
      ST_WCW: begin
        if (!div_busy) begin
          div_req.start = 1'b1;
          div_req.nbits = grc_pkg::CNT_W'(IW);
          div_req.num   = {y_q[PW-1:FW], {(NW-IW){1'b0}}};
          div_req.den   = DW'(tile_eff);
          state_d       = ST_WRW;
        end
      end
      ST_WRW: begin
        if (!div_busy) begin
          if (cell_fail) begin
            state_d = ST_PE;
          end else begin
            rd_en_o = 1'b1;
            state_d = ST_WM;
          end
        end
      end
      ST_WM: state_d = rd_data_i ? ST_DX : ST_WC;
      ST_DX: begin
        mul_a   = dx;
        mul_b   = grc_pkg::MUL_B_W'(dx);
        state_d = ST_DY;
      end
      ST_DY: begin
        mul_a   = dy;
        mul_b   = grc_pkg::MUL_B_W'(dy);
        state_d = ST_DS;
      end
      ST_DS: begin
        sq_start = 1'b1;
        state_d  = ST_DW;
      end
      ST_DW: begin
        if (!sq_busy) begin
          state_d = ST_PE;
        end
      end
      ST_PE: state_d = p_q ? ST_DONE : ST_PS;
      ST_DONE: begin
        if (res_ready_i) begin
          res_valid_o = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // shared multiplier
  always_ff @(posedge clk_i) begin
    mul_q <= grc_pkg::MUL_W'(mul_a) * grc_pkg::MUL_W'(mul_b);
  end

  // working registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          a_q     <= angle_i;
          px_q    <= pos_x_i;
          py_q    <= pos_y_i;
          right_q <= right_n;
          down_q  <= down_n;
          z_q     <= z_fold;
          cx_q    <= 34'sd536870912;
          cy_q    <= '0;
          i_q     <= '0;
          p_q     <= 1'b0;
          horiz_q <= '0;
          vert_q  <= '0;
        end
      end
      ST_ROT: begin
        if (!z_q[RW-1]) begin
          cx_q <= cx_q - sh_y;
          cy_q <= cy_q + sh_x;
          z_q  <= z_q - rot_c;
        end else begin
          cx_q <= cx_q + sh_y;
          cy_q <= cy_q - sh_x;
          z_q  <= z_q + rot_c;
        end
        i_q <= i_q + 1'b1;
      end
      ST_ABS: begin
        ac_q <= cx_q[RW-1] ? DW'(-cx_q) : cx_q[DW-1:0];
        as_q <= cy_q[RW-1] ? DW'(-cy_q) : cy_q[DW-1:0];
      end
      ST_BM: begin
        base_q <= base_n;
        d0_q   <= d0_n[TW:0];
      end
      ST_OW: begin
        if (!div_busy) begin
          off_q <= sat_off(quo);
        end
      end
      ST_SW: begin
        if (!div_busy) begin
          step_q <= sat_off(quo);
        end
      end
      ST_WS: begin
        if (!p_q) begin
          x_q  <= right_q ? px_c + off_c : px_c - off_c;
          y_q  <= base_c;
          sx_q <= right_q ? step_c : -step_c;
          sy_q <= down_q ? t_c : -t_c;
        end else begin
          x_q  <= base_c;
          y_q  <= down_q ? py_c + off_c : py_c - off_c;
          sx_q <= right_q ? t_c : -t_c;
          sy_q <= down_q ? step_c : -step_c;
        end
      end
      ST_WCW: begin
        if (!div_busy) begin
          col_q <= quo[IW-1:0];
        end
      end
      ST_WM: begin
        if (!rd_data_i) begin
          x_q <= x_q + sx_q;
          y_q <= y_q + sy_q;
        end
      end
      ST_DY: sq_q <= mul_q[SQW-2:0];
      ST_DW: begin
        if (!sq_busy) begin
          if (!p_q) begin
            horiz_q <= '{hit: 1'b1, x: x_q[PW-1:0], y: y_q[PW-1:0], dist_val: root};
          end else begin
            vert_q  <= '{hit: 1'b1, x: x_q[PW-1:0], y: y_q[PW-1:0], dist_val: root};
          end
        end
      end
      ST_PE: p_q <= 1'b1;
      default: ;
    endcase
  end

  assign idle_o  = state_q == ST_IDLE;
  assign horiz_o = horiz_q;
  assign vert_o  = vert_q;

endmodule

// File: design/grid_ray_wall_caster.sv
// Grid ray wall caster top level: config registers, item handshake, wall map and result register.
// After reset the wall map is cleared one cell per cycle over all MAP_COLS*MAP_ROWS cells
// (4096 by default), and no item is taken meanwhile; config writes are taken at any time. A
// write item is written into the map as it is taken. A cast item is worked out by the shared
// one-bit-per-cycle divider, which gives the offsets, the steps and the cell of every grid
// crossing that either of its two walks checks, and by the iterative root for each hit
// distance. A finished result waits in an output register while the next item is
// already taken.
module grid_ray_wall_caster #(
  parameter int MAP_COLS = grc_pkg::MAP_COLS_DEF,
  parameter int MAP_ROWS = grc_pkg::MAP_ROWS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [5:0]  cell_col_i,
  input  logic [5:0]  cell_row_i,
  input  logic        cell_wall_i,
  input  logic [19:0] pos_x_i,
  input  logic [19:0] pos_y_i,
  input  logic [15:0] ray_angle_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        horiz_hit_o,
  output logic [19:0] horiz_x_o,
  output logic [19:0] horiz_y_o,
  output logic [20:0] horiz_dist_o,
  output logic        vert_hit_o,
  output logic [19:0] vert_x_o,
  output logic [19:0] vert_y_o,
  output logic [20:0] vert_dist_o
);

  localparam int AW = $clog2(MAP_COLS * MAP_ROWS);

  logic [grc_pkg::TILE_W-1:0] tile_q;
  logic [grc_pkg::VIEW_W-1:0] view_w_q, view_h_q;
  logic                       cfg_wr;
  logic                       core_idle, map_busy, accept;
  logic                       res_valid, res_ready;
  grc_pkg::walk_res_t         core_h, core_v, out_h_q, out_v_q;
  logic                       out_valid_q;
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic                       rd_en, rd_data;
  logic [AW-1:0]              rd_addr;

  // config registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_q   <= 8'd64;
      view_w_q <= 12'd1024;
      view_h_q <= 12'd512;
    end else if (cfg_wr) begin
      unique case (grc_pkg::reg_idx_e'(paddr[3:2]))
        grc_pkg::REG_TILE:   tile_q   <= pwdata[grc_pkg::TILE_W-1:0];
        grc_pkg::REG_VIEW_W: view_w_q <= pwdata[grc_pkg::VIEW_W-1:0];
        grc_pkg::REG_VIEW_H: view_h_q <= pwdata[grc_pkg::VIEW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (grc_pkg::reg_idx_e'(paddr[3:2]))
      grc_pkg::REG_TILE:   prdata = 32'(tile_q);
      grc_pkg::REG_VIEW_W: prdata = 32'(view_w_q);
      grc_pkg::REG_VIEW_H: prdata = 32'(view_h_q);
      default:             prdata = '0;
    endcase
  end

  // input handshake
  assign in_stall_o = !(core_idle && !map_busy);
  assign accept     = in_valid_i && !in_stall_o;

  // map write item
  assign wr_en   = accept && !action_i && ({3'b0, cell_col_i} < 9'(MAP_COLS)) &&
                   ({3'b0, cell_row_i} < 9'(MAP_ROWS));
  assign wr_addr = AW'(cell_row_i) * AW'(MAP_COLS) + AW'(cell_col_i);

  grc_map #(
    .MAP_COLS (MAP_COLS),
    .MAP_ROWS (MAP_ROWS)
  ) u_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .busy_o    (map_busy),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (cell_wall_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  grc_core #(
    .MAP_COLS (MAP_COLS),
    .MAP_ROWS (MAP_ROWS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept && action_i),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .angle_i     (ray_angle_i[grc_pkg::ANGLE_W-1:0]),
    .tile_i      (tile_q),
    .view_w_i    (view_w_q),
    .view_h_i    (view_h_q),
    .idle_o      (core_idle),
    .res_ready_i (res_ready),
    .res_valid_o (res_valid),
    .horiz_o     (core_h),
    .vert_o      (core_v),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data)
  );

  // output register
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_h_q <= core_h;
      out_v_q <= core_v;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign horiz_hit_o  = out_h_q.hit;
  assign horiz_x_o    = out_h_q.x;
  assign horiz_y_o    = out_h_q.y;
  assign horiz_dist_o = out_h_q.dist_val;
  assign vert_hit_o   = out_v_q.hit;
  assign vert_x_o     = out_v_q.x;
  assign vert_y_o     = out_v_q.y;
  assign vert_dist_o  = out_v_q.dist_val;

endmodule
